>>> rtl/signed_integer_alu_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the signed integer ALU
// ---------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_ALU_MACROS_SVH
`define SIGNED_INTEGER_ALU_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define SIA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SIA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sia_pkg.sv
// ---------------------------------------------------------------------------
// sia_pkg
// Shared constants and types of the signed integer ALU.
// ---------------------------------------------------------------------------
package sia_pkg;

    localparam int unsigned DEFAULT_WIDTH = 32;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } action_t;

    typedef struct packed {
        logic ovf;
        logic zero;
        logic sign;
        logic carry;
        logic dbz;
    } flags_t;

endpackage

>>> rtl/sia_divider.sv
// ---------------------------------------------------------------------------
// sia_divider
// Pipelined signed restoring divider: one quotient bit per stage, WIDTH
// stages, plus sign fix-up stage. Advances when en is high.
// ---------------------------------------------------------------------------
module sia_divider #(
    parameter int unsigned WIDTH = sia_pkg::DEFAULT_WIDTH
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] a_in,
    input  logic [WIDTH-1:0] b_in,
    output logic [WIDTH-1:0] quot,
    output logic [WIDTH-1:0] rem,
    output logic             ovf,
    output logic             dbz
);
    import sia_pkg::*;

    logic [WIDTH-1:0] q_reg   [0:WIDTH];
    logic [WIDTH-1:0] r_reg   [0:WIDTH];
    logic [WIDTH-1:0] d_reg   [0:WIDTH];
    logic             qn_reg  [0:WIDTH];
    logic             rn_reg  [0:WIDTH];
    logic             ov_reg  [0:WIDTH];
    logic             z_reg   [0:WIDTH];
    logic [WIDTH-1:0] q_out_reg;
    logic [WIDTH-1:0] r_out_reg;
    logic             ov_out_reg;
    logic             z_out_reg;

    logic [WIDTH-1:0] ua;
    logic [WIDTH-1:0] ub;

    always_comb begin
        ua = a_in[WIDTH-1] ? (~a_in + 1'b1) : a_in;
        ub = b_in[WIDTH-1] ? (~b_in + 1'b1) : b_in;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg[0]  <= ua;
            r_reg[0]  <= '0;
            d_reg[0]  <= ub;
            qn_reg[0] <= a_in[WIDTH-1] ^ b_in[WIDTH-1];
            rn_reg[0] <= a_in[WIDTH-1];
            ov_reg[0] <= (a_in == {1'b1, {(WIDTH-1){1'b0}}}) && (&b_in);
            z_reg[0]  <= (b_in == '0);
        end
    end

    for (genvar s = 0; s < WIDTH; s++) begin : g_stage
        logic [WIDTH:0]   trial;
        logic [WIDTH:0]   diff;
        always_comb begin
            trial = {r_reg[s], q_reg[s][WIDTH-1]};
            diff  = trial - {1'b0, d_reg[s]};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!diff[WIDTH]) begin
                    r_reg[s+1] <= diff[WIDTH-1:0];
                    q_reg[s+1] <= {q_reg[s][WIDTH-2:0], 1'b1};
                end else begin
                    r_reg[s+1] <= trial[WIDTH-1:0];
                    q_reg[s+1] <= {q_reg[s][WIDTH-2:0], 1'b0};
                end
                d_reg[s+1]  <= d_reg[s];
                qn_reg[s+1] <= qn_reg[s];
                rn_reg[s+1] <= rn_reg[s];
                ov_reg[s+1] <= ov_reg[s];
                z_reg[s+1]  <= z_reg[s];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (z_reg[WIDTH]) begin
                q_out_reg <= '0;
                r_out_reg <= '0;
            end else begin
                q_out_reg <= qn_reg[WIDTH] ? (~q_reg[WIDTH] + 1'b1) : q_reg[WIDTH];
                r_out_reg <= rn_reg[WIDTH] ? (~r_reg[WIDTH] + 1'b1) : r_reg[WIDTH];
            end
            ov_out_reg <= ov_reg[WIDTH];
            z_out_reg  <= z_reg[WIDTH];
        end
    end

    assign quot = q_out_reg;
    assign rem  = r_out_reg;
    assign ovf  = ov_out_reg;
    assign dbz  = z_out_reg;

endmodule

>>> rtl/sia_multiplier.sv
// ---------------------------------------------------------------------------
// sia_multiplier
// Pipelined signed multiplier: radix-4 Booth partial products, one per
// stage, accumulated stage by stage, then aligned to the divider depth.
// ---------------------------------------------------------------------------
module sia_multiplier #(
    parameter int unsigned WIDTH = sia_pkg::DEFAULT_WIDTH,
    parameter int unsigned DEPTH = WIDTH + 2
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [WIDTH-1:0]   a_in,
    input  logic [WIDTH-1:0]   b_in,
    output logic [2*WIDTH-1:0] prod
);
    import sia_pkg::*;

    localparam int unsigned STEPS = (WIDTH + 1) / 2;
    localparam int unsigned PW    = 2 * WIDTH;
    localparam int unsigned BW    = 2 * STEPS + 1;

    logic [PW-1:0] acc_reg [0:STEPS];
    logic [PW-1:0] mc_reg  [0:STEPS];
    logic [BW-1:0] mp_reg  [0:STEPS];
    logic [PW-1:0] dly_reg [0:DEPTH-STEPS-2];

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg[0] <= '0;
            mc_reg[0]  <= {{WIDTH{a_in[WIDTH-1]}}, a_in};
            mp_reg[0]  <= BW'($signed({b_in, 1'b0}));
        end
    end

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        logic [2:0]    grp;
        logic [PW-1:0] pp;
        always_comb begin
            grp = mp_reg[s][2:0];
            case (grp)
                3'b001, 3'b010: pp = mc_reg[s];
                3'b011:         pp = mc_reg[s] << 1;
                3'b100:         pp = ~(mc_reg[s] << 1) + 1'b1;
                3'b101, 3'b110: pp = ~mc_reg[s] + 1'b1;
                default:        pp = '0;
            endcase
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                acc_reg[s+1] <= acc_reg[s] + pp;
                mc_reg[s+1]  <= mc_reg[s] << 2;
                mp_reg[s+1]  <= {{2{mp_reg[s][BW-1]}}, mp_reg[s][BW-1:2]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dly_reg[0] <= acc_reg[STEPS];
        end
    end
    for (genvar d = 1; d < DEPTH - STEPS - 1; d++) begin : g_dly
        always_ff @(posedge aclk) begin
            if (en) begin
                dly_reg[d] <= dly_reg[d-1];
            end
        end
    end

    assign prod = dly_reg[DEPTH-STEPS-2];

endmodule

>>> rtl/sia_adder.sv
// ---------------------------------------------------------------------------
// sia_adder
// Add/subtract with flags, registered, then delayed to the common latency.
// ---------------------------------------------------------------------------
module sia_adder #(
    parameter int unsigned WIDTH = sia_pkg::DEFAULT_WIDTH,
    parameter int unsigned DEPTH = WIDTH + 2
) (
    input  logic                aclk,
    input  logic                en,
    input  logic                sub,
    input  logic [WIDTH-1:0]    a_in,
    input  logic [WIDTH-1:0]    b_in,
    output logic [WIDTH-1:0]    sum,
    output sia_pkg::flags_t     flags
);
    import sia_pkg::*;

    logic [WIDTH-1:0] bb;
    logic [WIDTH-1:0] low;
    logic [WIDTH:0]   full;
    logic             cin;
    logic             cout;
    flags_t           f;

    logic [WIDTH-1:0] s_reg [0:DEPTH-1];
    flags_t           f_reg [0:DEPTH-1];

    always_comb begin
        bb   = sub ? (~b_in + 1'b1) : b_in;
        low  = {1'b0, a_in[WIDTH-2:0]} + {1'b0, bb[WIDTH-2:0]};
        cin  = low[WIDTH-1];
        full = {1'b0, a_in} + {1'b0, bb};
        cout = full[WIDTH];
        f.ovf   = cin ^ cout;
        f.zero  = (full[WIDTH-1:0] == '0);
        f.sign  = full[WIDTH-1];
        f.carry = cout;
        f.dbz   = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg[0] <= full[WIDTH-1:0];
            f_reg[0] <= f;
        end
    end
    for (genvar d = 1; d < DEPTH; d++) begin : g_dly
        always_ff @(posedge aclk) begin
            if (en) begin
                s_reg[d] <= s_reg[d-1];
                f_reg[d] <= f_reg[d-1];
            end
        end
    end

    assign sum   = s_reg[DEPTH-1];
    assign flags = f_reg[DEPTH-1];

endmodule

>>> rtl/signed_integer_alu.sv
// ---------------------------------------------------------------------------
// signed_integer_alu
// Signed add, subtract, Booth multiply and restoring divide.
//
// Input channel s_valid/s_ready carries action, operand_a and operand_b;
// result channel m_valid/m_ready returns one transaction per input.
// All operations run in parallel pipelines of WIDTH+2 stages plus the
// output register; one transaction is accepted per cycle unless the
// receiver stalls. The depth is set by the divider, one quotient bit
// per stage. When the receiver stalls with a result held, the whole
// pipeline freezes and s_ready drops in the same cycle; it returns with
// m_ready, and nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits; payload is not
// reset.
// ---------------------------------------------------------------------------
`include "signed_integer_alu_macros.svh"
module signed_integer_alu #(
    parameter int unsigned WIDTH = sia_pkg::DEFAULT_WIDTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_action,
    input  logic signed [WIDTH-1:0] s_operand_a,
    input  logic signed [WIDTH-1:0] s_operand_b,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [WIDTH-1:0] m_result_low,
    output logic signed [WIDTH-1:0] m_result_high,
    output logic                    m_flag_overflow,
    output logic                    m_flag_zero,
    output logic                    m_flag_sign,
    output logic                    m_flag_carry,
    output logic                    m_divide_by_zero
);
    import sia_pkg::*;

    localparam int unsigned DEPTH = WIDTH + 2;

    logic          v_reg   [0:DEPTH-1];
    action_t       act_reg [0:DEPTH-1];
    logic          out_v_reg;
    logic [WIDTH-1:0] lo_reg;
    logic [WIDTH-1:0] hi_reg;
    flags_t        fl_reg;

    logic          en;
    logic [WIDTH-1:0] sum;
    flags_t        af;
    logic [2*WIDTH-1:0] prod;
    logic [WIDTH-1:0] quot;
    logic [WIDTH-1:0] rem;
    logic          dov;
    logic          dz;

    logic [WIDTH-1:0] lo_next;
    logic [WIDTH-1:0] hi_next;
    flags_t        fl_next;

    assign en      = !out_v_reg || m_ready;
    assign s_ready = en;

    sia_adder #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_add (
        .aclk (aclk), .en (en), .sub (s_action == ACT_SUB),
        .a_in (s_operand_a), .b_in (s_operand_b), .sum (sum), .flags (af)
    );

    sia_multiplier #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_mul (
        .aclk (aclk), .en (en), .a_in (s_operand_a), .b_in (s_operand_b),
        .prod (prod)
    );

    sia_divider #(.WIDTH(WIDTH)) u_div (
        .aclk (aclk), .en (en), .a_in (s_operand_a), .b_in (s_operand_b),
        .quot (quot), .rem (rem), .ovf (dov), .dbz (dz)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= s_valid;
            for (int i = 1; i < DEPTH; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act_reg[0] <= action_t'(s_action);
            for (int i = 1; i < DEPTH; i++) begin
                act_reg[i] <= act_reg[i-1];
            end
        end
    end

    always_comb begin
        lo_next = sum;
        hi_next = '0;
        fl_next = af;
        case (act_reg[DEPTH-1])
            ACT_MUL: begin
                lo_next       = prod[WIDTH-1:0];
                hi_next       = prod[2*WIDTH-1:WIDTH];
                fl_next       = '0;
                fl_next.zero  = (prod == '0);
                fl_next.sign  = prod[2*WIDTH-1];
            end
            ACT_DIV: begin
                lo_next       = quot;
                hi_next       = rem;
                fl_next       = '0;
                fl_next.dbz   = dz;
                fl_next.ovf   = dov;
                fl_next.zero  = !dz && (quot == '0);
                fl_next.sign  = quot[WIDTH-1];
            end
            default: begin
                lo_next = sum;
                hi_next = '0;
                fl_next = af;
            end
        endcase
    end

    // output register loads whenever the pipeline advances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= v_reg[DEPTH-1] || (out_v_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (en && (v_reg[DEPTH-1] || !out_v_reg || m_ready)) begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            fl_reg <= fl_next;
        end
    end

    assign m_valid          = out_v_reg;
    assign m_result_low     = lo_reg;
    assign m_result_high    = hi_reg;
    assign m_flag_overflow  = fl_reg.ovf;
    assign m_flag_zero      = fl_reg.zero;
    assign m_flag_sign      = fl_reg.sign;
    assign m_flag_carry     = fl_reg.carry;
    assign m_divide_by_zero = fl_reg.dbz;

    `SIA_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready && !en, m_valid && $stable(m_result_low), "stalled result changed")
    `SIA_ASSERT_IMP(a_dbz, aclk, aresetn, m_valid && m_divide_by_zero, m_result_low == '0 && m_result_high == '0 && !m_flag_overflow, "divide by zero result not clear")
    `SIA_ASSERT_IMP(a_ready, aclk, aresetn, !m_valid, s_ready, "not ready with empty output")

endmodule

>>> bench/testbench.sv
// ---------------------------------------------------------------------------
// Signed integer ALU testbench
// Drives add, subtract, multiply and divide transactions through the
// valid/ready input channel, predicts each result in the bench and compares
// every returned transaction field by field, with random gaps on both sides
// and one long output stall that fills the pipeline.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sia_pkg::*;

    localparam int W = 32;
    localparam int LATENCY = W + 3;

    typedef struct {
        logic [W-1:0] low;
        logic [W-1:0] high;
        logic ovf, zero, sign, carry, dbz;
    } alu_result_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [1:0] s_action = '0;
    logic signed [W-1:0] s_operand_a = '0;
    logic signed [W-1:0] s_operand_b = '0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [W-1:0] m_result_low, m_result_high;
    logic m_flag_overflow, m_flag_zero, m_flag_sign, m_flag_carry, m_divide_by_zero;

    alu_result_t pending_results[$];
    int errors = 0;
    bit hold_off = 0;

    signed_integer_alu #(.WIDTH(W)) u_top (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic alu_result_t compute_alu(action_t op, logic [W-1:0] a,
                                                logic [W-1:0] b);
        alu_result_t r;
        logic [W:0] wide_sum;
        logic [W-1:0] addend, low_sum;
        logic signed [2*W-1:0] product;
        logic [W-1:0] ua, ub, q, rem;
        logic cin;
        r = '{default: '0};
        case (op)
            ACT_ADD, ACT_SUB: begin
                addend = (op == ACT_SUB) ? (~b + 1'b1) : b;
                wide_sum = {1'b0, a} + {1'b0, addend};
                low_sum = {1'b0, a[W-2:0]} + {1'b0, addend[W-2:0]};
                cin = low_sum[W-1];
                r.low = wide_sum[W-1:0];
                r.carry = wide_sum[W];
                r.ovf = cin ^ wide_sum[W];
                r.zero = (r.low == 0);
                r.sign = r.low[W-1];
            end
            ACT_MUL: begin
                product = $signed(a) * $signed(b);
                r.low = product[W-1:0];
                r.high = product[2*W-1:W];
                r.zero = (product == 0);
                r.sign = product[2*W-1];
            end
            default: begin
                if (b == 0) begin
                    r.dbz = 1;
                end else begin
                    ua = a[W-1] ? -a : a;
                    ub = b[W-1] ? -b : b;
                    q = ua / ub;
                    rem = ua % ub;
                    if (a[W-1] != b[W-1]) q = -q;
                    if (a[W-1]) rem = -rem;
                    r.low = q;
                    r.high = rem;
                    r.ovf = (a == {1'b1, {(W-1){1'b0}}}) && (b == '1);
                    r.zero = (q == 0);
                    r.sign = q[W-1];
                end
            end
        endcase
        return r;
    endfunction

    // gap in cycles, at least one: mostly short, a few long
    function automatic int gap_length();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
    endfunction

    task automatic send_op(action_t op, logic [W-1:0] a, logic [W-1:0] b, bit gaps);
        s_valid <= 1;
        s_action <= op;
        s_operand_a <= a;
        s_operand_b <= b;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(compute_alu(op, a, b));
        @(negedge aclk);
        if (gaps && $urandom_range(0, 2) == 0) begin
            s_valid <= 0;
            repeat (gap_length()) @(negedge aclk);
        end
    endtask

    function automatic logic [W-1:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(W-1){1'b0}}};
            1: return {1'b0, {(W-1){1'b1}}};
            2: return '1;
            3: return 0;
            4: return $urandom_range(0, 20) - 10;
            5: return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    // output side: random stalls, plus a long hold-off on request
    initial begin
        int n;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 0;
                for (n = 0; n < 3 * LATENCY; n++) @(negedge aclk);
                hold_off = 0;
                m_ready <= 1;
            end else if ($urandom_range(0, 5) == 0) begin
                m_ready <= 0;
                repeat (gap_length()) @(negedge aclk);
                m_ready <= 1;
            end else begin
                m_ready <= 1;
            end
        end
    end

    always @(posedge aclk) begin
        alu_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected transaction");
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_result_low !== e.low) begin
                    $error("result_low exp %h got %h", e.low, m_result_low); errors++;
                end
                if (m_result_high !== e.high) begin
                    $error("result_high exp %h got %h", e.high, m_result_high); errors++;
                end
                if (m_flag_overflow !== e.ovf) begin
                    $error("flag_overflow exp %b got %b", e.ovf, m_flag_overflow); errors++;
                end
                if (m_flag_zero !== e.zero) begin
                    $error("flag_zero exp %b got %b", e.zero, m_flag_zero); errors++;
                end
                if (m_flag_sign !== e.sign) begin
                    $error("flag_sign exp %b got %b", e.sign, m_flag_sign); errors++;
                end
                if (m_flag_carry !== e.carry) begin
                    $error("flag_carry exp %b got %b", e.carry, m_flag_carry); errors++;
                end
                if (m_divide_by_zero !== e.dbz) begin
                    $error("divide_by_zero exp %b got %b", e.dbz, m_divide_by_zero);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        logic [W-1:0] mn, mx;
        mn = {1'b1, {(W-1){1'b0}}};
        mx = {1'b0, {(W-1){1'b1}}};
        send_op(ACT_ADD, mx, 1, 0);
        send_op(ACT_ADD, mn, mn, 0);
        send_op(ACT_ADD, '1, 1, 0);
        send_op(ACT_ADD, '0, '0, 0);
        send_op(ACT_SUB, 5, 0, 0);
        send_op(ACT_SUB, mn, 1, 0);
        send_op(ACT_SUB, 0, mn, 0);
        send_op(ACT_SUB, 7, 7, 0);
        send_op(ACT_MUL, mn, mn, 0);
        send_op(ACT_MUL, mx, mn, 0);
        send_op(ACT_MUL, '1, '1, 0);
        send_op(ACT_MUL, 0, mx, 0);
        send_op(ACT_MUL, -3, 7, 0);
        send_op(ACT_DIV, 7, 0, 0);
        send_op(ACT_DIV, mn, '1, 0);
        send_op(ACT_DIV, -7, 2, 0);
        send_op(ACT_DIV, 7, -2, 0);
        send_op(ACT_DIV, -7, -2, 0);
        send_op(ACT_DIV, 6, 3, 0);
        send_op(ACT_DIV, 1, mn, 0);
        send_op(ACT_DIV, mn, mn, 0);
        send_op(ACT_DIV, mx, 1, 0);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            send_op(action_t'($urandom_range(0, 3)), rand_operand(), rand_operand(), 1);
        end
        s_valid <= 0;
    endtask

    task automatic test_backpressure();
        hold_off = 1;
        for (int i = 0; i < 2 * LATENCY; i++) begin
            send_op(action_t'($urandom_range(0, 3)), $urandom, $urandom, 0);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        test_directed();
        test_backpressure();
        test_random(310);
        wait (pending_results.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
